/* sv/ntg_pkg.sv */
// ============================================================================
// ntg_pkg
// Shared types and constants of the square-wave note tone generator.
// ============================================================================
package ntg_pkg;

    // payload widths
    localparam int FREQ_W    = 15;
    localparam int VALUE_W   = 8;
    localparam int CFG_W     = 22;
    localparam int DIVISOR_W = 20;
    localparam int TOGGLE_W  = 17;
    localparam int HALF_W    = 19;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    // constants of the timing math
    localparam logic [DIVISOR_W-1:0] US_PER_S   = 20'd1000000;
    localparam logic [TOGGLE_W-1:0]  TOGGLE_MAX = 17'd131071;
    localparam logic [CFG_W-1:0]     WHOLE_RST  = 22'd1200000;
    localparam logic [CFG_W-1:0]     BREAK_RST  = 22'd1000000;

    // register indexes (paddr[2])
    localparam logic REG_WHOLE_IDX = 1'b0;
    localparam logic REG_BREAK_IDX = 1'b1;

    // input item codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // note phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TONE,
        PH_REST,
        PH_PAUSE
    } phase_t;

    // divide sequencer state
    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_DUR,
        SQ_PAUSE,
        SQ_PERIOD,
        SQ_TOGGLES
    } seq_state_t;

endpackage

/* sv/ntg_if.sv */
// ============================================================================
// ntg_if
// Valid/ready channels for note items and result items.
// ============================================================================
interface ntg_in_if;
    import ntg_pkg::*;

    logic               valid;
    logic               ready;
    logic               op;
    logic [FREQ_W-1:0]  frequency_hz;
    logic [VALUE_W-1:0] note_value;

    modport source (output valid, op, frequency_hz, note_value, input ready);
    modport sink   (input valid, op, frequency_hz, note_value, output ready);
endinterface

interface ntg_out_if;
    logic valid;
    logic ready;
    logic speaker_level;
    logic busy_res;
    logic note_done;
    logic rejected;

    modport source (output valid, speaker_level, busy_res, note_done, rejected,
                    input ready);
    modport sink   (input valid, speaker_level, busy_res, note_done, rejected,
                    output ready);
endinterface

/* sv/ntg_apb.sv */
// ============================================================================
// ntg_apb
// APB-style register port holding the whole-note and pause base times.
// ============================================================================
module ntg_apb #(
    parameter int CW = 22
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ntg_pkg::ADDR_W-1:0] paddr,
    input  logic [ntg_pkg::DATA_W-1:0] pwdata,
    output logic [ntg_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output logic [CW-1:0]              whole_note_us,
    output logic [CW-1:0]              break_base_us
);
    import ntg_pkg::*;

    logic [CW-1:0] whole_reg;
    logic [CW-1:0] break_reg;
    logic          wr_en;
    logic          idx;

    assign pready = 1'b1;
    assign idx    = paddr[2];
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            whole_reg <= WHOLE_RST[CW-1:0];
            break_reg <= BREAK_RST[CW-1:0];
        end
        else if (wr_en)
        begin
            if (idx == REG_WHOLE_IDX)
            begin
                whole_reg <= pwdata[CW-1:0];
            end
            else
            begin
                break_reg <= pwdata[CW-1:0];
            end
        end
    end

    // read mux
    always_comb
    begin
        if (idx == REG_BREAK_IDX)
        begin
            prdata = DATA_W'(break_reg);
        end
        else
        begin
            prdata = DATA_W'(whole_reg);
        end
    end

    assign whole_note_us = whole_reg;
    assign break_base_us = break_reg;

endmodule

/* sv/ntg_div.sv */
// ============================================================================
// ntg_div
// Shared restoring divider, one quotient bit per cycle.
// ============================================================================
module ntg_div #(
    parameter int DIV_W = 22,
    parameter int VW    = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [VW-1:0]    divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);
    localparam int CNT_BITS = $clog2(DIV_W + 1);

    logic [VW-1:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]    q_reg, q_next;
    logic [VW-1:0]       dsr_reg, dsr_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [VW:0]         shifted;
    logic [VW:0]         diff;
    logic                ge;

    // one trial subtraction
    assign shifted = {rem_reg, q_reg[DIV_W-1]};
    assign ge      = (shifted >= {1'b0, dsr_reg});
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            q_next   = dividend;
            dsr_next = divisor;
            cnt_next = CNT_BITS'(DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? diff[VW-1:0] : shifted[VW-1:0];
            q_next    = {q_reg[DIV_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* sv/ntg_seq.sv */
// ============================================================================
// ntg_seq
// Note sequencer: tick timing of tone, rest and pause, and the divide
// sequence that sets up a note on start.
// ============================================================================
module ntg_seq #(
    parameter int TIME_BITS = 22,
    parameter int CW        = 22,
    parameter int DIV_W     = 22,
    parameter int CNT_W     = 22
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ntg_in_if.sink                        note_in,
    ntg_out_if.source                     note_out,
    input  logic [CW-1:0]                 whole_note_us,
    input  logic [CW-1:0]                 break_base_us,
    output logic                          div_start,
    output logic [DIV_W-1:0]              div_dividend,
    output logic [ntg_pkg::DIVISOR_W-1:0] div_divisor,
    input  logic                          div_done,
    input  logic [DIV_W-1:0]              div_quotient
);
    import ntg_pkg::*;

    seq_state_t          state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic                level_reg, level_next;
    logic [TOGGLE_W-1:0] toggles_reg, toggles_next;
    logic [HALF_W-1:0]   half_reg, half_next;
    logic [CNT_W-1:0]    tick_reg, tick_next;
    logic [CW-1:0]       pause_reg, pause_next;
    logic [CW-1:0]       duration_reg, duration_next;
    logic [FREQ_W-1:0]   freq_reg, freq_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_level_reg, out_level_next;
    logic                out_busy_reg, out_busy_next;
    logic                out_done_reg, out_done_next;
    logic                out_rej_reg, out_rej_next;

    logic                in_fire;
    logic                start_rej;
    logic                tk_entered;
    phase_t              tk_phase;
    logic                tk_level;
    logic [TOGGLE_W-1:0] tk_toggles;
    logic [CNT_W-1:0]    tk_tick;
    logic                tk_done;
    logic [HALF_W-1:0]   half_eff;
    logic [CNT_W-1:0]    tick_inc;
    logic [TIME_BITS-1:0] pause_inc;
    logic [CNT_W-1:0]    rest_dec;
    logic [TOGGLE_W-1:0] tg_sat;

    // handshake
    assign note_in.ready = (state_reg == SQ_IDLE) && (!out_valid_reg || note_out.ready);
    assign in_fire       = note_in.valid && note_in.ready;
    assign start_rej     = (note_in.note_value == '0) || (phase_reg != PH_IDLE);

    // one microsecond of note timing
    always_comb
    begin
        tk_phase   = phase_reg;
        tk_level   = level_reg;
        tk_toggles = toggles_reg;
        tk_tick    = tick_reg;
        tk_done    = 1'b0;
        tk_entered = 1'b0;
        half_eff   = (half_reg == '0) ? HALF_W'(1) : half_reg;
        tick_inc   = tick_reg + 1'b1;
        pause_inc  = tick_reg[TIME_BITS-1:0] + 1'b1;
        rest_dec   = (tick_reg != '0) ? (tick_reg - 1'b1) : tick_reg;
        case (phase_reg)
            PH_TONE:
            begin
                if (tick_reg == '0)
                begin
                    tk_level = ~level_reg;
                    if (toggles_reg != '0)
                    begin
                        tk_toggles = toggles_reg - 1'b1;
                    end
                end
                tk_tick = tick_inc;
                if (tick_inc >= CNT_W'(half_eff))
                begin
                    tk_tick = '0;
                    if (tk_toggles == '0)
                    begin
                        tk_phase   = PH_PAUSE;
                        tk_entered = 1'b1;
                    end
                end
            end
            PH_REST:
            begin
                tk_tick = rest_dec;
                if (rest_dec == '0)
                begin
                    tk_phase   = PH_PAUSE;
                    tk_entered = 1'b1;
                end
            end
            PH_PAUSE:
            begin
                tk_tick = CNT_W'(pause_inc);
                if ((CNT_W'(pause_inc) >= CNT_W'(pause_reg)) || (pause_inc == '0))
                begin
                    tk_phase = PH_IDLE;
                    tk_tick  = '0;
                    tk_done  = 1'b1;
                end
            end
            default:
            begin
                tk_phase = phase_reg;
            end
        endcase
        // empty pause ends the note on the same tick
        if (tk_entered && (pause_reg == '0))
        begin
            tk_phase = PH_IDLE;
            tk_tick  = '0;
            tk_done  = 1'b1;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SQ_IDLE:
            begin
                if (in_fire && (note_in.op == OP_START) && !start_rej)
                begin
                    state_next = SQ_DUR;
                end
            end
            SQ_DUR:
            begin
                if (div_done)
                begin
                    state_next = SQ_PAUSE;
                end
            end
            SQ_PAUSE:
            begin
                if (div_done)
                begin
                    state_next = (freq_reg == '0) ? SQ_IDLE : SQ_PERIOD;
                end
            end
            SQ_PERIOD:
            begin
                if (div_done)
                begin
                    state_next = SQ_TOGGLES;
                end
            end
            SQ_TOGGLES:
            begin
                if (div_done)
                begin
                    state_next = SQ_IDLE;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    // divider operands per step
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = DIV_W'(whole_note_us);
        div_divisor  = DIVISOR_W'(val_reg);
        case (state_reg)
            SQ_IDLE:
            begin
                div_start    = in_fire && (note_in.op == OP_START) && !start_rej;
                div_dividend = DIV_W'(whole_note_us);
                div_divisor  = DIVISOR_W'(note_in.note_value);
            end
            SQ_DUR:
            begin
                div_start    = div_done;
                div_dividend = DIV_W'(break_base_us);
                div_divisor  = DIVISOR_W'(val_reg);
            end
            SQ_PAUSE:
            begin
                div_start    = div_done && (freq_reg != '0);
                div_dividend = DIV_W'(US_PER_S);
                div_divisor  = DIVISOR_W'(freq_reg);
            end
            SQ_PERIOD:
            begin
                div_start    = div_done;
                div_dividend = DIV_W'(duration_reg);
                div_divisor  = div_quotient[DIVISOR_W-1:0];
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // saturated toggle count
    assign tg_sat = (div_quotient > DIV_W'(TOGGLE_MAX)) ? TOGGLE_MAX
                                                       : div_quotient[TOGGLE_W-1:0];

    // note state and result beat
    always_comb
    begin
        phase_next     = phase_reg;
        level_next     = level_reg;
        toggles_next   = toggles_reg;
        half_next      = half_reg;
        tick_next      = tick_reg;
        pause_next     = pause_reg;
        duration_next  = duration_reg;
        freq_next      = freq_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg && !note_out.ready;
        out_level_next = out_level_reg;
        out_busy_next  = out_busy_reg;
        out_done_next  = out_done_reg;
        out_rej_next   = out_rej_reg;

        if (in_fire)
        begin
            if (note_in.op == OP_TICK)
            begin
                phase_next     = tk_phase;
                level_next     = tk_level;
                toggles_next   = tk_toggles;
                tick_next      = tk_tick;
                out_valid_next = 1'b1;
                out_level_next = tk_level;
                out_busy_next  = (tk_phase != PH_IDLE);
                out_done_next  = tk_done;
                out_rej_next   = 1'b0;
            end
            else if (start_rej)
            begin
                out_valid_next = 1'b1;
                out_level_next = level_reg;
                out_busy_next  = (phase_reg != PH_IDLE);
                out_done_next  = 1'b0;
                out_rej_next   = 1'b1;
            end
            else
            begin
                freq_next = note_in.frequency_hz;
                val_next  = note_in.note_value;
            end
        end

        if (div_done)
        begin
            case (state_reg)
                SQ_DUR:
                begin
                    duration_next = div_quotient[CW-1:0];
                end
                SQ_PAUSE:
                begin
                    pause_next = div_quotient[CW-1:0];
                    if (freq_reg == '0)
                    begin
                        toggles_next = '0;
                        half_next    = '0;
                        if (duration_reg != '0)
                        begin
                            phase_next = PH_REST;
                            tick_next  = CNT_W'(duration_reg);
                        end
                        else
                        begin
                            phase_next = PH_PAUSE;
                            tick_next  = '0;
                        end
                        out_valid_next = 1'b1;
                        out_level_next = level_reg;
                        out_busy_next  = 1'b1;
                        out_done_next  = 1'b0;
                        out_rej_next   = 1'b0;
                    end
                end
                SQ_PERIOD:
                begin
                    half_next = div_quotient[HALF_W:1];
                end
                SQ_TOGGLES:
                begin
                    toggles_next   = tg_sat;
                    tick_next      = '0;
                    phase_next     = (tg_sat != '0) ? PH_TONE : PH_PAUSE;
                    out_valid_next = 1'b1;
                    out_level_next = level_reg;
                    out_busy_next  = 1'b1;
                    out_done_next  = 1'b0;
                    out_rej_next   = 1'b0;
                end
                default:
                begin
                    duration_next = duration_reg;
                end
            endcase
        end
    end

    // control and note state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SQ_IDLE;
            phase_reg     <= PH_IDLE;
            level_reg     <= 1'b0;
            toggles_reg   <= '0;
            half_reg      <= '0;
            tick_reg      <= '0;
            pause_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            level_reg     <= level_next;
            toggles_reg   <= toggles_next;
            half_reg      <= half_next;
            tick_reg      <= tick_next;
            pause_reg     <= pause_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        duration_reg  <= duration_next;
        freq_reg      <= freq_next;
        val_reg       <= val_next;
        out_level_reg <= out_level_next;
        out_busy_reg  <= out_busy_next;
        out_done_reg  <= out_done_next;
        out_rej_reg   <= out_rej_next;
    end

    assign note_out.valid         = out_valid_reg;
    assign note_out.speaker_level = out_level_reg;
    assign note_out.busy_res      = out_busy_reg;
    assign note_out.note_done     = out_done_reg;
    assign note_out.rejected      = out_rej_reg;

endmodule

/* sv/note_tone_generator_top.sv */
// ============================================================================
// note_tone_generator_top
// Square-wave note tone generator driven by one-microsecond tick beats.
// ============================================================================
// Usage:
//   note_in carries one beat per tick (op = tick) or per note start
//   (op = start, with frequency_hz and note_value). Every accepted beat
//   gives exactly one result beat on note_out: speaker level, busy,
//   note_done on the tick that ends the pause, rejected for a refused start.
//   A tick or a refused start needs no division; its result is registered and
//   shows the cycle after acceptance, and the next beat can be taken then.
//   An accepted start runs four divisions on one shared restoring divider
//   (duration, pause, period, toggle count), where DIV_W =
//   max(min(TIME_BITS, 22), 20) sets the divider width; a start with a
//   rest frequency stops after two, and note_in.ready stays low meanwhile.
//   If note_out stalls, the result stays registered and note_in.ready drops
//   until the result beat is taken.
//   Reset clears the note to idle with the speaker low and loads the base
//   times; the user must write both via the APB port while idle (unenforced).
// ============================================================================
module note_tone_generator_top #(
    parameter int TIME_BITS = 22
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ntg_in_if.sink                     note_in,
    ntg_out_if.source                  note_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ntg_pkg::ADDR_W-1:0] paddr,
    input  logic [ntg_pkg::DATA_W-1:0] pwdata,
    output logic [ntg_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import ntg_pkg::*;

    localparam int CW    = (TIME_BITS < CFG_W) ? TIME_BITS : CFG_W;
    localparam int DIV_W = (CW > DIVISOR_W) ? CW : DIVISOR_W;
    localparam int CNT_W = (TIME_BITS > DIVISOR_W) ? TIME_BITS : DIVISOR_W;

    logic [CW-1:0]        whole_note_us;
    logic [CW-1:0]        break_base_us;
    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quotient;

    // configuration registers
    ntg_apb #(
        .CW (CW)
    ) u_apb (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .whole_note_us (whole_note_us),
        .break_base_us (break_base_us)
    );

    // shared divider
    ntg_div #(
        .DIV_W (DIV_W),
        .VW    (DIVISOR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // sequencer and note timing
    ntg_seq #(
        .TIME_BITS (TIME_BITS),
        .CW        (CW),
        .DIV_W     (DIV_W),
        .CNT_W     (CNT_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .note_in       (note_in),
        .note_out      (note_out),
        .whole_note_us (whole_note_us),
        .break_base_us (break_base_us),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_done      (div_done),
        .div_quotient  (div_quotient)
    );

endmodule

/* sv/ntg_checker.sv */
// ============================================================================
// ntg_checker
// Port-level checks of the note tone generator, bound to the top level.
// ============================================================================
module ntg_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic op,
    input logic [ntg_pkg::VALUE_W-1:0] note_value,
    input logic out_valid,
    input logic out_ready,
    input logic speaker_level,
    input logic busy_res,
    input logic note_done,
    input logic rejected
);
    import ntg_pkg::*;

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(speaker_level)
            && $stable(busy_res) && $stable(note_done) && $stable(rejected))
        else $error("stalled result beat changed");

    // a tick gives its result on the next cycle and is never rejected
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == OP_TICK) |=> out_valid && !rejected)
        else $error("tick result missing or rejected");

    // a start with zero note value is refused at once
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == OP_START) && (note_value == '0)
            |=> out_valid && rejected && !note_done)
        else $error("zero note value not rejected");

    // note end leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && note_done |-> !busy_res && !rejected)
        else $error("note done while still busy");

endmodule

bind note_tone_generator_top ntg_checker u_ntg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (note_in.valid),
    .in_ready      (note_in.ready),
    .op            (note_in.op),
    .note_value    (note_in.note_value),
    .out_valid     (note_out.valid),
    .out_ready     (note_out.ready),
    .speaker_level (note_out.speaker_level),
    .busy_res      (note_out.busy_res),
    .note_done     (note_out.note_done),
    .rejected      (note_out.rejected)
);

/* verif/note_tone_generator_top_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// note_tone_generator_top_tb
// Self-checking bench for the square-wave note tone generator: tick and
// start beats are driven with random gaps, every result beat is compared
// against a cycle-free model of the tone, rest and pause timing, and the
// base note and pause times are reprogrammed over APB between melodies.
// ============================================================================
module note_tone_generator_top_tb;
    import ntg_pkg::*;

    localparam int TIME_BITS    = 22;
    localparam int RANDOM_BEATS = 1500;
    localparam int ERROR_PRINTS = 50;

    typedef struct packed {
        logic level;
        logic busy;
        logic done;
        logic rejected;
    } note_result_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    ntg_in_if  note_in ();
    ntg_out_if note_out ();

    note_tone_generator_top #(
        .TIME_BITS (TIME_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .note_in  (note_in),
        .note_out (note_out),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // tone model state and programmed base times
    logic [CFG_W-1:0]     whole_us;
    logic [CFG_W-1:0]     break_us;
    logic                 tone_level;
    phase_t               note_phase;
    logic [TOGGLE_W-1:0]  toggles_left;
    logic [HALF_W-1:0]    half_len;
    logic [TIME_BITS-1:0] tick_cnt;
    logic [TIME_BITS-1:0] pause_len;

    note_result_t expected_results[$];

    // bench controls and counters
    bit in_idle_on;
    bit out_idle_on;
    int hold_request;
    int beats_sent;
    int results_seen;
    int notes_finished;
    int starts_refused;
    int errors;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #30_000_000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_error(input string msg);
        errors++;
        if (errors <= ERROR_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // tone model
    // ------------------------------------------------------------------------
    function automatic void clear_tone();
        whole_us     = WHOLE_RST;
        break_us     = BREAK_RST;
        tone_level   = 1'b0;
        note_phase   = PH_IDLE;
        toggles_left = '0;
        half_len     = '0;
        tick_cnt     = '0;
        pause_len    = '0;
    endfunction

    // one microsecond step; returns 1 on the tick that ends the pause
    function automatic bit advance_tick();
        bit               to_pause;
        logic [HALF_W-1:0] half;
        to_pause = 1'b0;
        case (note_phase)
            PH_TONE:
            begin
                half = (half_len != '0) ? half_len : HALF_W'(1);
                if (tick_cnt == '0)
                begin
                    tone_level = ~tone_level;
                    if (toggles_left != '0)
                        toggles_left = toggles_left - 1'b1;
                end
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= half)
                begin
                    tick_cnt = '0;
                    if (toggles_left == '0)
                    begin
                        note_phase = PH_PAUSE;
                        to_pause   = 1'b1;
                    end
                end
            end
            PH_REST:
            begin
                if (tick_cnt != '0)
                    tick_cnt = tick_cnt - 1'b1;
                if (tick_cnt == '0)
                begin
                    note_phase = PH_PAUSE;
                    to_pause   = 1'b1;
                end
            end
            PH_PAUSE:
            begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= pause_len || tick_cnt == '0)
                begin
                    note_phase = PH_IDLE;
                    tick_cnt   = '0;
                    return 1'b1;
                end
            end
            default: ;
        endcase
        if (to_pause && pause_len == '0)
        begin
            note_phase = PH_IDLE;
            tick_cnt   = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // note start; returns 1 when the start is refused
    function automatic bit begin_note(input logic [FREQ_W-1:0] freq,
                                      input logic [VALUE_W-1:0] nval);
        longint unsigned dur;
        longint unsigned period;
        longint unsigned toggles;
        if (nval == '0 || note_phase != PH_IDLE)
            return 1'b1;
        dur          = whole_us / nval;
        pause_len    = TIME_BITS'(break_us / nval);
        tick_cnt     = '0;
        toggles_left = '0;
        half_len     = '0;
        if (freq == '0)
        begin
            if (dur > 0)
            begin
                note_phase = PH_REST;
                tick_cnt   = TIME_BITS'(dur);
            end
            else
                note_phase = PH_PAUSE;
        end
        else
        begin
            period  = US_PER_S / freq;
            toggles = dur / period;
            if (toggles > TOGGLE_MAX)
                toggles = TOGGLE_MAX;
            half_len     = HALF_W'(period / 2);
            toggles_left = TOGGLE_W'(toggles);
            note_phase   = (toggles > 0) ? PH_TONE : PH_PAUSE;
        end
        return 1'b0;
    endfunction

    function automatic note_result_t predict_result(input logic op,
                                                    input logic [FREQ_W-1:0] freq,
                                                    input logic [VALUE_W-1:0] nval);
        note_result_t r;
        r.done     = 1'b0;
        r.rejected = 1'b0;
        if (op == OP_TICK)
            r.done = advance_tick();
        else
            r.rejected = begin_note(freq, nval);
        r.level = tone_level;
        r.busy  = (note_phase != PH_IDLE);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result side: ready with random stalls and long hold-offs
    // ------------------------------------------------------------------------
    initial
    begin : out_ready_driver
        int stall;
        note_out.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                stall        = hold_request;
                hold_request = 0;
            end
            else
                stall = out_idle_on ? $urandom_range(0, 19) : 0;
            if (stall > 0)
            begin
                note_out.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            note_out.ready <= 1'b1;
            do @(posedge clk); while (note_out.valid !== 1'b1);
        end
    end

    task automatic check_field(input string field, input logic got, input logic want);
        if (got !== want)
            report_error($sformatf("result %0d %s: got %b, expected %b",
                                   results_seen, field, got, want));
    endtask

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        note_result_t want;
        if (rst_n === 1'b1 && note_out.valid === 1'b1 && note_out.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
                report_error("result beat with no expectation pending");
            else
            begin
                want = expected_results.pop_front();
                check_field("speaker_level", note_out.speaker_level, want.level);
                check_field("busy_res", note_out.busy_res, want.busy);
                check_field("note_done", note_out.note_done, want.done);
                check_field("rejected", note_out.rejected, want.rejected);
            end
            results_seen++;
            if (note_out.note_done === 1'b1)
                notes_finished++;
            if (note_out.rejected === 1'b1)
                starts_refused++;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // one beat on note_in; valid stays high afterwards for back-to-back beats
    task automatic send_beat(input logic op, input logic [FREQ_W-1:0] freq,
                             input logic [VALUE_W-1:0] nval);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            note_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        note_in.valid        <= 1'b1;
        note_in.op           <= op;
        note_in.frequency_hz <= freq;
        note_in.note_value   <= nval;
        do @(posedge clk); while (note_in.ready !== 1'b1);
        expected_results.push_back(predict_result(op, freq, nval));
        beats_sent++;
    endtask

    task automatic send_tick();
        send_beat(OP_TICK, FREQ_W'($urandom_range(0, 32767)), VALUE_W'($urandom_range(0, 255)));
    endtask

    // stop offering and wait for every result
    task automatic wait_idle();
        note_in.valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (idx == REG_WHOLE_IDX)
            whole_us = data[CFG_W-1:0];
        else
            break_us = data[CFG_W-1:0];
    endtask

    task automatic write_base_times(input int unsigned whole, input int unsigned brk);
        apb_write(REG_WHOLE_IDX, DATA_W'(whole));
        apb_write(REG_BREAK_IDX, DATA_W'(brk));
    endtask

    // ticks until the note and its pause are over, with stray starts if noisy
    task automatic finish_note(input bit noisy);
        while (note_phase != PH_IDLE)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_beat(OP_START, FREQ_W'($urandom_range(0, 32767)),
                          VALUE_W'($urandom_range(0, 255)));
            else
                send_tick();
        end
    endtask

    task automatic play_note(input logic [FREQ_W-1:0] freq, input logic [VALUE_W-1:0] nval,
                             input bit noisy);
        send_beat(OP_START, freq, nval);
        finish_note(noisy);
    endtask

    function automatic logic [FREQ_W-1:0] random_freq();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return '0;
        if (r < 4)
            return FREQ_W'($urandom_range(1, 32767));
        return FREQ_W'($urandom_range(5000, 32767));
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return VALUE_W'($urandom_range(1, 3));
        if (r < 9)
            return VALUE_W'($urandom_range(0, 255));
        return '0;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // idle ticks and a zero note value at the reset base times
    task automatic test_idle_and_reject();
        send_beat(OP_TICK, '0, '0);
        send_beat(OP_TICK, 15'h7FFF, 8'hFF);
        send_beat(OP_START, 15'd440, '0);
        send_beat(OP_TICK, '0, 8'd1);
        wait_idle();
    endtask

    // notes with no tone and no pause, most also with no rest, at near-minimal base times
    task automatic test_zero_length_notes();
        write_base_times(1, 0);
        play_note('0, 8'd1, 1'b0);
        play_note('0, 8'd2, 1'b0);
        play_note(15'd1, 8'd1, 1'b0);
        play_note(15'h7FFF, 8'hFF, 1'b0);
        wait_idle();
    endtask

    // short tones and rests, a start while busy, level kept after a note
    task automatic test_short_notes();
        write_base_times(300, 0);
        send_beat(OP_START, 15'd20000, 8'd1);
        send_tick();
        send_beat(OP_START, 15'd440, 8'd4);
        finish_note(1'b0);
        send_tick();
        wait_idle();
        write_base_times(100, 40);
        play_note(15'h7FFF, 8'd2, 1'b0);
        play_note('0, 8'd4, 1'b0);
        play_note(15'd1000, 8'd1, 1'b0);
        send_tick();
        wait_idle();
    endtask

    // largest whole-note time with no pause, played back to back with no gaps
    task automatic test_longest_note();
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        write_base_times(4194303, 0);
        play_note(15'd1, 8'hFF, 1'b1);
        wait_idle();
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_result_hold();
        write_base_times(200, 20);
        in_idle_on   = 1'b0;
        hold_request = 250;
        play_note(15'd20000, 8'd1, 1'b0);
        in_idle_on = 1'b1;
        wait_idle();
    endtask

    // random melodies over several base time settings
    task automatic test_random_melody();
        int target;
        int notes_left;
        int stage;
        int pick;
        target     = beats_sent + RANDOM_BEATS;
        notes_left = 0;
        stage      = 0;
        while (beats_sent < target)
        begin
            if (notes_left == 0)
            begin
                wait_idle();
                write_base_times($urandom_range(30, 250),
                                 ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120));
                in_idle_on  = !(stage & 1);
                out_idle_on = !(stage & 2);
                stage++;
                notes_left = $urandom_range(3, 7);
            end
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                // loose beats of either kind, then let any note run out
                repeat ($urandom_range(1, 6))
                    send_beat(1'($urandom_range(0, 1)), FREQ_W'($urandom_range(0, 32767)),
                              VALUE_W'($urandom_range(0, 255)));
                finish_note(1'b1);
            end
            else
            begin
                if (pick == 1)
                    repeat ($urandom_range(1, 3)) send_tick();
                play_note(random_freq(), random_value(), pick < 5);
            end
            notes_left--;
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                <= 1'b0;
        note_in.valid        <= 1'b0;
        note_in.op           <= OP_TICK;
        note_in.frequency_hz <= '0;
        note_in.note_value   <= '0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        in_idle_on            = 1'b1;
        out_idle_on           = 1'b1;
        hold_request          = 0;
        clear_tone();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_reject();
        test_zero_length_notes();
        test_short_notes();
        test_longest_note();
        test_result_hold();
        test_random_melody();

        // drain and settle
        note_in.valid <= 1'b0;
        for (int i = 0; i < 2000 && expected_results.size() != 0; i++)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (expected_results.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_results.size()));

        $display("sent %0d tick and start beats, checked %0d results", beats_sent,
                 results_seen);
        $display("%0d notes ran to completion, %0d starts refused, %0d mismatches",
                 notes_finished, starts_refused, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
